// File: rtl/sbmpl_pkg.sv
package sbmpl_pkg;

   localparam int NUM_MOTORS   = 4;
   localparam int CMD_W        = 16;
   localparam int BUF_W        = 10;
   localparam int MAX_W        = 14;
   localparam int BUFC_W       = 6;
   localparam int DCONST_W     = 12;
   localparam int ABS_W        = CMD_W + 1;
   localparam int TOT_W        = ABS_W + $clog2(NUM_MOTORS);
   localparam int LIM_W        = MAX_W + 2;
   localparam int LIM1_W       = LIM_W + BUFC_W;
   localparam int NUMER_W      = LIM1_W + BUFC_W;
   localparam int DEN_W        = TOT_W + DCONST_W;
   localparam int PROD_W       = ABS_W + NUMER_W;
   localparam int Q_W          = CMD_W;
   localparam int MID_DEPTH    = 5;
   localparam int OUT_DEPTH    = 32;

   localparam logic [MAX_W-1:0]    MAX_RESET  = MAX_W'(8000);
   localparam logic [BUFC_W-1:0]   BUF_CLAMP  = BUFC_W'(60);
   localparam logic [BUFC_W-1:0]   BUF_SQUARE = BUFC_W'(25);
   localparam logic [DCONST_W-1:0] DEN_ONE    = DCONST_W'(1);
   localparam logic [DCONST_W-1:0] DEN_LIN    = DCONST_W'(60);
   localparam logic [DCONST_W-1:0] DEN_SQ     = DCONST_W'(3600);

   typedef logic [NUM_MOTORS-1:0][CMD_W-1:0] cmd_vec_type;

   typedef struct packed {
      logic [NUM_MOTORS-1:0][PROD_W-1:0] prod;
      logic [DEN_W-1:0]                  den;
      logic [NUM_MOTORS-1:0]             neg;
      cmd_vec_type                       cmd;
      logic                              limited;
      logic                              zero;
   } mid_type;

   typedef struct packed {
      logic [NUM_MOTORS-1:0][PROD_W-1:0] rem;
      logic [NUM_MOTORS-1:0][Q_W-1:0]    quo;
      logic [DEN_W-1:0]                  den;
      logic [NUM_MOTORS-1:0]             neg;
      cmd_vec_type                       cmd;
      logic                              limited;
      logic                              zero;
   } div_type;

   typedef struct packed {
      cmd_vec_type out;
      logic        was_limited;
   } rsp_type;

endpackage

// File: rtl/sbmpl_fifo.sv
module sbmpl_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_pop;

   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/sbmpl_front.sv
module sbmpl_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [sbmpl_pkg::BUF_W-1:0]  in_buf,
   input  sbmpl_pkg::cmd_vec_type       in_cmd,
   input  logic [sbmpl_pkg::MAX_W-1:0]  max_per_motor,
   output logic                         out_valid,
   output sbmpl_pkg::mid_type           out_item
);
   import sbmpl_pkg::*;

   // stage 1: clamp, magnitudes, total, first limit product
   logic                              s1_valid_ff;
   logic [NUM_MOTORS-1:0][ABS_W-1:0]  s1_abs_ff, s1_abs_in;
   logic [NUM_MOTORS-1:0]             s1_neg_ff, s1_neg_in;
   cmd_vec_type                       s1_cmd_ff;
   logic [TOT_W-1:0]                  s1_total_ff, s1_total_in;
   logic [LIM1_W-1:0]                 s1_lim_ff, s1_lim_in;
   logic [BUFC_W-1:0]                 s1_buf_ff, s1_buf_in;
   logic                              s1_sq_ff, s1_sq_in;
   logic                              s1_full_ff, s1_full_in;
   logic [LIM_W-1:0]                  lim_full;
   logic [ABS_W-1:0]                  sext;

   // stage 2: numerator and scaled total
   logic                              s2_valid_ff;
   logic [NUMER_W-1:0]                s2_numer_ff, s2_numer_in;
   logic [DEN_W-1:0]                  s2_den_ff, s2_den_in;
   logic [NUM_MOTORS-1:0][ABS_W-1:0]  s2_abs_ff;
   logic [NUM_MOTORS-1:0]             s2_neg_ff;
   cmd_vec_type                       s2_cmd_ff;
   logic                              s2_zero_ff;
   logic [DCONST_W-1:0]               dconst;

   // stage 3: dividends and limit test
   logic                              s3_valid_ff;
   mid_type                           s3_item_ff, s3_item_in;

   always_comb begin
      lim_full   = {max_per_motor, 2'b00};
      s1_buf_in  = (in_buf > BUF_W'(BUF_CLAMP)) ? BUF_CLAMP : in_buf[BUFC_W-1:0];
      s1_full_in = (s1_buf_in == BUF_CLAMP);
      s1_sq_in   = (s1_buf_in < BUF_SQUARE);
      s1_lim_in  = s1_full_in ? LIM1_W'(lim_full) : LIM1_W'(lim_full) * LIM1_W'(s1_buf_in);
      s1_total_in = '0;
      sext        = '0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
         sext         = {in_cmd[i][CMD_W-1], in_cmd[i]};
         s1_neg_in[i] = in_cmd[i][CMD_W-1];
         s1_abs_in[i] = s1_neg_in[i] ? (~sext + 1'b1) : sext;
         s1_total_in  = s1_total_in + TOT_W'(s1_abs_in[i]);
      end
   end

   always_comb begin
      s2_numer_in = s1_sq_ff ? NUMER_W'(s1_lim_ff) * NUMER_W'(s1_buf_ff)
                             : NUMER_W'(s1_lim_ff);
      if (s1_full_ff) begin
         dconst = DEN_ONE;
      end else if (s1_sq_ff) begin
         dconst = DEN_SQ;
      end else begin
         dconst = DEN_LIN;
      end
      s2_den_in = DEN_W'(s1_total_ff) * DEN_W'(dconst);
   end

   always_comb begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
         s3_item_in.prod[i] = PROD_W'(s2_abs_ff[i]) * PROD_W'(s2_numer_ff);
      end
      s3_item_in.den     = s2_den_ff;
      s3_item_in.neg     = s2_neg_ff;
      s3_item_in.cmd     = s2_cmd_ff;
      s3_item_in.limited = (DEN_W'(s2_numer_ff) <= s2_den_ff);
      s3_item_in.zero    = s2_zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_abs_ff   <= s1_abs_in;
      s1_neg_ff   <= s1_neg_in;
      s1_cmd_ff   <= in_cmd;
      s1_total_ff <= s1_total_in;
      s1_lim_ff   <= s1_lim_in;
      s1_buf_ff   <= s1_buf_in;
      s1_sq_ff    <= s1_sq_in;
      s1_full_ff  <= s1_full_in;
      s2_numer_ff <= s2_numer_in;
      s2_den_ff   <= s2_den_in;
      s2_abs_ff   <= s1_abs_ff;
      s2_neg_ff   <= s1_neg_ff;
      s2_cmd_ff   <= s1_cmd_ff;
      s2_zero_ff  <= (s1_total_ff == '0);
      s3_item_ff  <= s3_item_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_item_ff;

endmodule

// File: rtl/sbmpl_back.sv
module sbmpl_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  sbmpl_pkg::mid_type  in_item,
   output logic                out_valid,
   output sbmpl_pkg::rsp_type  out_item
);
   import sbmpl_pkg::*;

   localparam int DIV_W = PROD_W + 2;

   logic    valid_ff [Q_W+1];
   div_type stage_ff [Q_W+1];
   div_type head;
   rsp_type res;

   // one quotient bit per stage, restoring
   function automatic div_type div_step(input div_type st, input int sh);
      div_type          nxt;
      logic [DIV_W-1:0] dsh;
      logic [DIV_W-1:0] rem;
      nxt = st;
      dsh = DIV_W'(st.den) << sh;
      for (int i = 0; i < NUM_MOTORS; i++) begin
         rem = DIV_W'(st.rem[i]);
         if (rem >= dsh) begin
            nxt.rem[i]     = PROD_W'(rem - dsh);
            nxt.quo[i][sh] = 1'b1;
         end
      end
      return nxt;
   endfunction

   always_comb begin
      head.rem     = in_item.prod;
      head.quo     = '0;
      head.den     = in_item.den;
      head.neg     = in_item.neg;
      head.cmd     = in_item.cmd;
      head.limited = in_item.limited;
      head.zero    = in_item.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= Q_W; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int s = 0; s < Q_W; s++) begin
            valid_ff[s+1] <= valid_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      stage_ff[0] <= head;
      for (int s = 0; s < Q_W; s++) begin
         stage_ff[s+1] <= div_step(stage_ff[s], Q_W - 1 - s);
      end
   end

   always_comb begin
      res.was_limited = stage_ff[Q_W].limited;
      for (int i = 0; i < NUM_MOTORS; i++) begin
         if (!stage_ff[Q_W].limited) begin
            res.out[i] = stage_ff[Q_W].cmd[i];
         end else if (stage_ff[Q_W].zero) begin
            res.out[i] = '0;
         end else if (stage_ff[Q_W].neg[i]) begin
            res.out[i] = CMD_W'(~stage_ff[Q_W].quo[i] + 1'b1);
         end else begin
            res.out[i] = CMD_W'(stage_ff[Q_W].quo[i]);
         end
      end
   end

   assign out_valid = valid_ff[Q_W];
   assign out_item  = res;

endmodule

// File: rtl/buffer_scaled_motor_power_limit.sv
// Buffer-scaled motor power limit. Takes one command set per clock while req_full is low, on a
// queue-style port, and returns the limited commands in order. An item passes through the front
// pipeline (clamp, limit products, dividends), a 5-entry queue, and the back divider (an input
// register plus one quotient bit per stage for each motor) before landing in a 32-entry result
// queue. The 5 front credits cover the trip from acceptance to issue, so the sustained rate is
// one item per cycle while results are taken. The per-motor maximum is written through
// csr_wr_en/csr_wr_data and should only change while no item is in flight.
module buffer_scaled_motor_power_limit #(
   parameter int MID_DEPTH = sbmpl_pkg::MID_DEPTH,
   parameter int OUT_DEPTH = sbmpl_pkg::OUT_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [sbmpl_pkg::BUF_W-1:0]  req_buffer_energy,
   input  logic [sbmpl_pkg::CMD_W-1:0]  req_cmd_a,
   input  logic [sbmpl_pkg::CMD_W-1:0]  req_cmd_b,
   input  logic [sbmpl_pkg::CMD_W-1:0]  req_cmd_c,
   input  logic [sbmpl_pkg::CMD_W-1:0]  req_cmd_d,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [sbmpl_pkg::CMD_W-1:0]  rsp_out_a,
   output logic [sbmpl_pkg::CMD_W-1:0]  rsp_out_b,
   output logic [sbmpl_pkg::CMD_W-1:0]  rsp_out_c,
   output logic [sbmpl_pkg::CMD_W-1:0]  rsp_out_d,
   output logic                         rsp_was_limited,
   input  logic                         csr_wr_en,
   input  logic [sbmpl_pkg::MAX_W-1:0]  csr_wr_data
);
   import sbmpl_pkg::*;

   localparam int MCNT_W = $clog2(MID_DEPTH + 1);
   localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

   logic [MAX_W-1:0]  max_ff;
   logic [MCNT_W-1:0] front_cnt_ff, front_cnt_in;
   logic [OCNT_W-1:0] back_cnt_ff, back_cnt_in;
   logic              accept;
   logic              issue;
   logic              rsp_take;
   cmd_vec_type       cmd_vec;
   logic              front_valid;
   mid_type           front_item;
   mid_type           mid_item;
   logic              mid_empty;
   logic              back_valid;
   rsp_type           back_item;
   rsp_type           rsp_item;

   assign cmd_vec  = {req_cmd_d, req_cmd_c, req_cmd_b, req_cmd_a};
   assign req_full = (front_cnt_ff == MCNT_W'(MID_DEPTH));
   assign accept   = req_push && !req_full;
   assign issue    = !mid_empty && (back_cnt_ff != OCNT_W'(OUT_DEPTH));
   assign rsp_take = rsp_pop && !rsp_empty;

   // credits: front items until they leave the mid queue, back items until popped
   always_comb begin
      front_cnt_in = front_cnt_ff;
      back_cnt_in  = back_cnt_ff;
      if (accept && !issue) begin
         front_cnt_in = front_cnt_ff + 1'b1;
      end else if (!accept && issue) begin
         front_cnt_in = front_cnt_ff - 1'b1;
      end
      if (issue && !rsp_take) begin
         back_cnt_in = back_cnt_ff + 1'b1;
      end else if (!issue && rsp_take) begin
         back_cnt_in = back_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= MAX_RESET;
         front_cnt_ff <= '0;
         back_cnt_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
         front_cnt_ff <= front_cnt_in;
         back_cnt_ff  <= back_cnt_in;
      end
   end

   sbmpl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .in_buf        (req_buffer_energy),
      .in_cmd        (cmd_vec),
      .max_per_motor (max_ff),
      .out_valid     (front_valid),
      .out_item      (front_item)
   );

   sbmpl_fifo #(
      .WIDTH ($bits(mid_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_item),
      .pop       (issue),
      .pop_data  (mid_item),
      .empty     (mid_empty)
   );

   sbmpl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (issue),
      .in_item   (mid_item),
      .out_valid (back_valid),
      .out_item  (back_item)
   );

   sbmpl_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid),
      .push_data (back_item),
      .pop       (rsp_take),
      .pop_data  (rsp_item),
      .empty     (rsp_empty)
   );

   assign rsp_out_a       = rsp_item.out[0];
   assign rsp_out_b       = rsp_item.out[1];
   assign rsp_out_c       = rsp_item.out[2];
   assign rsp_out_d       = rsp_item.out[3];
   assign rsp_was_limited = rsp_item.was_limited;

endmodule

// File: rtl/sbmpl_checker.sv
module sbmpl_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_full,
   input logic                         rsp_empty,
   input logic                         rsp_pop,
   input logic [sbmpl_pkg::CMD_W-1:0]  rsp_out_a,
   input logic [sbmpl_pkg::CMD_W-1:0]  rsp_out_b,
   input logic [sbmpl_pkg::CMD_W-1:0]  rsp_out_c,
   input logic [sbmpl_pkg::CMD_W-1:0]  rsp_out_d,
   input logic                         rsp_was_limited
);

   // nothing waits right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input full after reset");

   // a waiting beat stays until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("result beat dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_out_a) && $stable(rsp_out_b)
         && $stable(rsp_out_c) && $stable(rsp_out_d) && $stable(rsp_was_limited))
      else $error("result beat changed while waiting");

endmodule

bind buffer_scaled_motor_power_limit sbmpl_checker u_sbmpl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_out_a       (rsp_out_a),
   .rsp_out_b       (rsp_out_b),
   .rsp_out_c       (rsp_out_c),
   .rsp_out_d       (rsp_out_d),
   .rsp_was_limited (rsp_was_limited)
);
